// File: src/bmde_pkg.sv
// Package for the battery meter display encoder.
// Holds the payload types, the fixed conversion constants and the segment, bar and digit helpers.
// Depends on nothing.
package bmde_pkg;

   localparam int unsigned RawWidth     = 16;
   localparam int unsigned StatusWidth  = 8;
   localparam int unsigned DisplayWidth = 29;
   localparam int unsigned PercentWidth = 7;
   localparam int unsigned MvWidth      = 14;
   localparam int unsigned VoltWidth    = 10;

   localparam logic [MvWidth-1:0]      MvOffset     = 14'd3000;
   localparam logic [StatusWidth-1:0]  PercentModeMask = 8'h10;
   localparam logic [PercentWidth-1:0] PercentMax   = 7'd100;
   localparam logic [VoltWidth-1:0]    VoltMax      = 10'd999;
   localparam logic [16:0]             Recip10      = 17'd52429;  // 2^19 / 10, rounded up
   localparam int unsigned             Recip10Shift = 19;

   localparam logic [2:0] IndPercent = 3'b001;
   localparam logic [2:0] IndVolts   = 3'b110;

   localparam logic [3:0] SegBlank = 4'd10;

   typedef logic [3:0] digit_type;

   typedef struct packed {
      digit_type hundreds;
      digit_type tens;
      digit_type ones;
   } digits_type;

   typedef struct packed {
      logic [MvWidth-1:0]      millivolts_value;
      logic [PercentWidth-1:0] percent_level;
      logic                    error_flag;
      logic [DisplayWidth-1:0] display_word;
   } rsp_payload_type;

   // Seven-segment pattern, segment a in bit 0; blank code and unused codes light nothing.
   function automatic logic [6:0] seg7(input digit_type d);
      logic [6:0] s;
      case (d)
         4'd0: s = 7'h3F;
         4'd1: s = 7'h06;
         4'd2: s = 7'h5B;
         4'd3: s = 7'h4F;
         4'd4: s = 7'h66;
         4'd5: s = 7'h6D;
         4'd6: s = 7'h7D;
         4'd7: s = 7'h07;
         4'd8: s = 7'h7F;
         4'd9: s = 7'h6F;
         default: s = 7'h00;
      endcase
      return s;
   endfunction

   function automatic logic [4:0] level_bars(input logic [PercentWidth-1:0] pct);
      logic [4:0] b;
      if (pct >= 7'd90)      b = 5'h1F;
      else if (pct >= 7'd70) b = 5'h0F;
      else if (pct >= 7'd50) b = 5'h07;
      else if (pct >= 7'd30) b = 5'h03;
      else if (pct >= 7'd5)  b = 5'h01;
      else                   b = 5'h00;
      return b;
   endfunction

   // Split 0..999 into decimal digits by parallel threshold compares.
   function automatic digits_type split_digits(input logic [VoltWidth-1:0] v);
      digits_type       d;
      logic [VoltWidth-1:0] rem;
      d.hundreds = 4'd0;
      for (int k = 1; k < 10; k++) begin
         if (v >= VoltWidth'(k * 100)) d.hundreds = 4'(k);
      end
      rem = v - VoltWidth'(d.hundreds) * 10'd100;
      d.tens = 4'd0;
      for (int k = 1; k < 10; k++) begin
         if (rem >= VoltWidth'(k * 10)) d.tens = 4'(k);
      end
      rem = rem - VoltWidth'(d.tens) * 10'd10;
      d.ones = rem[3:0];
      return d;
   endfunction

endpackage

// File: src/battery_meter_display_encoder_unit.sv
// Top level of the battery meter display encoder.
// Holds the input register, result register and stored display word around bmde_encode.
// Depends on bmde_pkg and bmde_encode.

// One request (signed half-millivolt reading plus status byte) is taken per
// cycle and its result passes first through the input register and then
// through the result register, with the whole conversion (a single
// constant reciprocal multiply for volts, threshold compares for digits and
// bars) in between. Throughput is one request per clock as long as the result
// side takes its data; a stalled result holds both registers, and the input
// register still fills once while the result waits. A negative reading
// raises the error flag, reports zero percent and millivolts, and repeats the
// last good display word, which reset clears to zero.
module battery_meter_display_encoder_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [15:0] voltage_raw (signed)
   input  logic [7:0]  req_tuser,   // [7:0] status_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,   // [28:0] display_word, [35:29] percent_level,
                                    // [49:36] millivolts_value, [55:50] zero
   output logic [0:0]  rsp_tuser    // [0] error_flag
);
   import bmde_pkg::*;

   logic                    s1_valid_ff, s1_valid_in;
   logic [RawWidth-1:0]     raw_ff, raw_in;
   logic [StatusWidth-1:0]  status_ff, status_in;
   logic                    out_valid_ff, out_valid_in;
   rsp_payload_type         payload_ff, payload_in;
   logic [DisplayWidth-1:0] shown_ff, shown_in;

   rsp_payload_type         result;
   logic                    advance;
   logic                    take;

   bmde_encode u_encode (
      .raw    (raw_ff),
      .status (status_ff),
      .shown  (shown_ff),
      .result (result)
   );

   // Advance the input stage when the result register is free or being drained.
   assign advance    = s1_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || advance;
   assign take       = req_tvalid && req_tready;

   always_comb begin
      s1_valid_in  = s1_valid_ff;
      raw_in       = raw_ff;
      status_in    = status_ff;
      out_valid_in = out_valid_ff;
      payload_in   = payload_ff;
      shown_in     = shown_ff;

      if (advance) s1_valid_in = 1'b0;
      if (take) begin
         s1_valid_in = 1'b1;
         raw_in      = req_tdata;
         status_in   = req_tuser;
      end

      if (out_valid_ff && rsp_tready) out_valid_in = 1'b0;
      if (advance) begin
         out_valid_in = 1'b1;
         payload_in   = result;
         // On error the encoder passes the stored word through, so this keeps it.
         shown_in     = result.display_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         shown_ff     <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
         shown_ff     <= shown_in;
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      raw_ff     <= raw_in;
      status_ff  <= status_in;
      payload_ff <= payload_in;
   end

   assign rsp_tvalid   = out_valid_ff;
   assign rsp_tdata    = {6'd0, payload_ff.millivolts_value, payload_ff.percent_level,
                          payload_ff.display_word};
   assign rsp_tuser[0] = payload_ff.error_flag;

endmodule

// File: src/bmde_encode.sv
// Conversion datapath of the battery meter display encoder.
// Turns one registered reading into millivolts, percent and the display word.
// Depends on bmde_pkg.
module bmde_encode (
   input  logic [bmde_pkg::RawWidth-1:0]     raw,
   input  logic [bmde_pkg::StatusWidth-1:0]  status,
   input  logic [bmde_pkg::DisplayWidth-1:0] shown,
   output bmde_pkg::rsp_payload_type         result
);
   import bmde_pkg::*;

   logic                    negative;
   logic [MvWidth-1:0]      mv;
   logic [MvWidth-1:0]      mv_off;
   logic [10:0]             pct_wide;
   logic [PercentWidth-1:0] pct;
   logic [MvWidth:0]        volt_sum;
   logic [31:0]             volt_prod;
   logic [12:0]             volt_quot;
   logic [VoltWidth-1:0]    volt;
   logic                    pct_mode;
   digits_type              dig;
   digit_type               d_left;
   digit_type               d_mid;
   logic [DisplayWidth-1:0] word;

   always_comb begin
      negative = raw[RawWidth-1];
      mv       = raw[MvWidth:1];

      // Charge percent: eight millivolts a step above the empty point, capped at full.
      mv_off   = mv - MvOffset;
      pct_wide = mv_off[MvWidth-1:3];
      if (mv < MvOffset)                      pct = '0;
      else if (pct_wide > 11'(PercentMax))    pct = PercentMax;
      else                                    pct = pct_wide[PercentWidth-1:0];

      // Rounded hundredths of volts through a reciprocal multiply.
      volt_sum  = {1'b0, mv} + 15'd5;
      volt_prod = 32'(volt_sum) * 32'(Recip10);
      volt_quot = volt_prod[Recip10Shift+12:Recip10Shift];
      volt      = (volt_quot > 13'(VoltMax)) ? VoltMax : volt_quot[VoltWidth-1:0];

      pct_mode = (status & PercentModeMask) != '0;
      dig      = split_digits(pct_mode ? VoltWidth'(pct) : volt);
      d_left   = dig.hundreds;
      d_mid    = dig.tens;
      // Blank leading zeros in percent mode only.
      if (pct_mode && dig.hundreds == 4'd0) begin
         d_left = SegBlank;
         if (dig.tens == 4'd0) d_mid = SegBlank;
      end

      word = {level_bars(pct), seg7(d_left), seg7(d_mid), seg7(dig.ones),
              pct_mode ? IndPercent : IndVolts};

      if (negative) begin
         result.display_word     = shown;
         result.error_flag       = 1'b1;
         result.percent_level    = '0;
         result.millivolts_value = '0;
      end else begin
         result.display_word     = word;
         result.error_flag       = 1'b0;
         result.percent_level    = pct;
         result.millivolts_value = mv;
      end
   end

endmodule

// File: src/bmde_checker.sv
// Port-level checker for the battery meter display encoder.
// Watches only the top-level ports; bound to battery_meter_display_encoder_unit below.
// Depends on nothing.
module bmde_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [55:0] rsp_tdata,
   input logic [0:0]  rsp_tuser
);

   // An error result reports zero percent and zero millivolts.
   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata[49:29] == 21'd0)
      else $error("error result carries nonzero percent or millivolts");

   // Percent never exceeds full, and padding stays zero.
   a_pct_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[35:29] <= 7'd100 && rsp_tdata[55:50] == 6'd0)
      else $error("percent out of range or padding set");

   // A good result shows exactly one mode indicator pattern.
   a_indicator: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |->
         rsp_tdata[2:0] == 3'b001 || rsp_tdata[2:0] == 3'b110)
      else $error("bad mode indicator bits");

   // A stalled result holds.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result changed");

endmodule

bind battery_meter_display_encoder_unit bmde_checker u_bmde_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

// File: verif/battery_meter_display_encoder_unit_tb.sv
// Self-checking testbench for battery_meter_display_encoder_unit.
// Drives readings over the request stream and checks every result against a predicted or hand-written one.
// Depends on bmde_pkg and the RTL of the unit.
module battery_meter_display_encoder_unit_tb;
   import bmde_pkg::*;

   localparam int unsigned RandomPerPhase = 150;
   localparam int unsigned DigitBlank     = 10;
   localparam int unsigned LongHold       = 60;   // receiver hold-off to back up the pipe
   localparam int unsigned DrainCycles    = 10;   // two-stage pipe, plus margin
   localparam int unsigned ReportLimit    = 10;

   typedef struct packed {
      logic [RawWidth-1:0]    raw;
      logic [StatusWidth-1:0] status;
      bit                     typed;   // want holds a hand-written result
      rsp_payload_type        want;
   } reading_row_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [RawWidth-1:0]    req_tdata;   // [15:0] voltage_raw (signed)
   logic [StatusWidth-1:0] req_tuser;   // [7:0] status_byte
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [55:0]            rsp_tdata;   // [28:0] display_word, [35:29] percent_level,
                                        // [49:36] millivolts_value, [55:50] zero
   logic [0:0]             rsp_tuser;   // [0] error_flag

   // Side band that travels with the request, so the monitor sees the typed
   // expectation belonging to the request accepted at that edge.
   bit                     row_typed;
   rsp_payload_type        row_want;

   reading_row_type        directed_rows[$];
   rsp_payload_type        pending_readouts[$];
   logic [DisplayWidth-1:0] shown_word;   // predictor copy of the stored display word
   int unsigned            mismatch_count;
   int unsigned            stray_count;
   int unsigned            tx_idle_pct;
   int unsigned            rx_stall_pct;
   bit                     hold_request;
   int unsigned            hold_left;

   battery_meter_display_encoder_unit uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Segment a sits in bit 0; the blank code lights nothing.
   function automatic logic [6:0] segments_of(input int unsigned digit);
      logic [6:0] s;
      case (digit)
         0: s = 7'b0111111;
         1: s = 7'b0000110;
         2: s = 7'b1011011;
         3: s = 7'b1001111;
         4: s = 7'b1100110;
         5: s = 7'b1101101;
         6: s = 7'b1111101;
         7: s = 7'b0000111;
         8: s = 7'b1111111;
         9: s = 7'b1101111;
         default: s = 7'b0000000;
      endcase
      return s;
   endfunction

   // Work out the result of one reading given the word currently on display.
   function automatic rsp_payload_type predict_reading(input logic [RawWidth-1:0] raw,
                                                       input logic [StatusWidth-1:0] status,
                                                       input logic [DisplayWidth-1:0] prev);
      rsp_payload_type r;
      int unsigned     mv;
      int unsigned     pct;
      int unsigned     shown_value;
      int unsigned     hi;
      int unsigned     mid;
      int unsigned     lo;
      logic [4:0]      bars;
      logic [2:0]      ind;
      r = '0;
      // Negative reading: repeat the stored word, report nothing else.
      if (raw[RawWidth-1]) begin
         r.display_word = prev;
         r.error_flag   = 1'b1;
         return r;
      end
      mv  = raw >> 1;
      pct = (mv < 3000) ? 0 : ((mv - 3000) >> 3);
      if (pct > 100) pct = 100;
      if ((status & PercentModeMask) != '0) begin
         hi  = pct / 100;
         mid = (pct / 10) % 10;
         lo  = pct % 10;
         // Blank the leading zeros of the percent figure.
         if (hi == 0) begin
            hi = DigitBlank;
            if (mid == 0) mid = DigitBlank;
         end
         ind = IndPercent;
      end else begin
         shown_value = (mv + 5) / 10;   // hundredths of a volt, rounded
         if (shown_value > 999) shown_value = 999;
         hi  = shown_value / 100;
         mid = (shown_value / 10) % 10;
         lo  = shown_value % 10;
         ind = IndVolts;
      end
      if (pct >= 90)      bars = 5'b11111;
      else if (pct >= 70) bars = 5'b01111;
      else if (pct >= 50) bars = 5'b00111;
      else if (pct >= 30) bars = 5'b00011;
      else if (pct >= 5)  bars = 5'b00001;
      else                bars = 5'b00000;
      r.display_word     = {bars, segments_of(hi), segments_of(mid), segments_of(lo), ind};
      r.percent_level    = pct[PercentWidth-1:0];
      r.millivolts_value = mv[MvWidth-1:0];
      return r;
   endfunction

   function automatic void add_row(input logic [RawWidth-1:0] raw,
                                   input logic [StatusWidth-1:0] status,
                                   input bit typed = 1'b0,
                                   input logic [DisplayWidth-1:0] word = '0,
                                   input bit err = 1'b0,
                                   input logic [PercentWidth-1:0] pct = '0,
                                   input logic [MvWidth-1:0] mv = '0);
      reading_row_type row;
      row.raw                   = raw;
      row.status                = status;
      row.typed                 = typed;
      row.want.display_word     = word;
      row.want.error_flag       = err;
      row.want.percent_level    = pct;
      row.want.millivolts_value = mv;
      directed_rows.push_back(row);
   endfunction

   // Offer one request, idling first at the current sender rate, and hold it
   // until the block takes it.
   task automatic offer_reading(input logic [RawWidth-1:0] raw,
                                input logic [StatusWidth-1:0] status,
                                input bit typed,
                                input rsp_payload_type want);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         req_tdata  <= RawWidth'($urandom);
         req_tuser  <= StatusWidth'($urandom);
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= raw;
      req_tuser  <= status;
      row_typed  <= typed;
      row_want   <= want;
      do @(posedge clock); while (!req_tready);
   endtask

   // Random reading: mostly the percent range and the volts saturation knee,
   // with full-range values and wiring errors mixed in.
   function automatic logic [RawWidth-1:0] random_reading();
      logic [RawWidth-1:0] raw;
      case ($urandom_range(9))
         0:       raw = 16'h8000 | RawWidth'($urandom_range(16'h7FFF));
         1, 2:    raw = RawWidth'($urandom);
         3, 4, 5, 6: raw = RawWidth'($urandom_range(7700, 5900));
         7:       raw = RawWidth'($urandom_range(20050, 19900));
         default: raw = RawWidth'($urandom_range(32767));
      endcase
      return raw;
   endfunction

   // Request monitor: predict on every accepted request, in order.
   always @(posedge clock) begin
      rsp_payload_type pred;
      if (!reset && req_tvalid && req_tready) begin
         pred = predict_reading(req_tdata, req_tuser, shown_word);
         if (!pred.error_flag) shown_word <= pred.display_word;
         pending_readouts.push_back(row_typed ? row_want : pred);
      end
   end

   // Result monitor: compare each accepted result with the oldest expectation.
   always @(posedge clock) begin
      rsp_payload_type want;
      rsp_payload_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.display_word     = rsp_tdata[28:0];
         got.percent_level    = rsp_tdata[35:29];
         got.millivolts_value = rsp_tdata[49:36];
         got.error_flag       = rsp_tuser[0];
         if (pending_readouts.size() == 0) begin
            stray_count++;
            if (mismatch_count + stray_count <= ReportLimit)
               $display("tb: unexpected result word=%h err=%0d pct=%0d mv=%0d",
                        got.display_word, got.error_flag, got.percent_level,
                        got.millivolts_value);
         end else begin
            want = pending_readouts.pop_front();
            if (got.display_word !== want.display_word || got.error_flag !== want.error_flag ||
                got.percent_level !== want.percent_level ||
                got.millivolts_value !== want.millivolts_value) begin
               mismatch_count++;
               if (mismatch_count + stray_count <= ReportLimit)
                  $display("tb: mismatch word/err/pct/mv exp %h/%0d/%0d/%0d got %h/%0d/%0d/%0d",
                           want.display_word, want.error_flag, want.percent_level,
                           want.millivolts_value, got.display_word, got.error_flag,
                           got.percent_level, got.millivolts_value);
            end
         end
      end
   end

   // Receiver: stall at the current rate, or hold off entirely for a long
   // stretch when asked, so the block fills up and drops req_tready.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_request) begin
         hold_request = 1'b0;
         hold_left    = LongHold;
         rsp_tready  <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left   = hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rx_stall_pct);
      end
   end

   // Run limit, far beyond the slowest correct run.
   initial begin
      #5_000_000;
      $display("tb: failure");
      $finish;
   end

   initial begin
      rsp_payload_type none;
      none           = '0;
      req_tvalid    <= 1'b0;
      req_tdata     <= '0;
      req_tuser     <= '0;
      row_typed     <= 1'b0;
      row_want      <= '0;
      shown_word     = '0;
      mismatch_count = 0;
      stray_count    = 0;
      tx_idle_pct    = 0;
      rx_stall_pct   = 0;
      hold_request   = 1'b0;
      hold_left      = 0;

      // Wiring errors straight after reset repeat the cleared display.
      add_row(16'h8000, 8'h00, 1, 29'h0, 1, 0, 0);
      add_row(16'hFFFF, 8'hFF, 1, 29'h0, 1, 0, 0);
      // Zero reading: volts shows 0.00, percent shows a lone 0.
      add_row(16'h0000, 8'h00, 1, 29'h07EFDFE, 0, 0, 0);
      add_row(16'h0000, 8'h10, 1, 29'h00001F9, 0, 0, 0);
      // Full-scale reading: 100 percent with five bars, volts saturated at 9.99.
      add_row(16'h7FFF, 8'h10, 1, 29'h1F0CFDF9, 0, 100, 14'h3FFF);
      add_row(16'h7FFF, 8'hEF, 1, 29'h1FDFBF7E, 0, 100, 14'h3FFF);
      // Error after a good word repeats that word.
      add_row(16'h8001, 8'h10, 1, 29'h1FDFBF7E, 1, 0, 0);
      // Low-voltage edge, each bar threshold, tens blanking, volts rounding
      // and the saturation knee go through the predictor.
      add_row(16'd5999, 8'h10);
      add_row(16'd6000, 8'h10);
      add_row(16'd6078, 8'h10);
      add_row(16'd6080, 8'h10);
      add_row(16'd6144, 8'h10);
      add_row(16'd6160, 8'h10);
      add_row(16'd6464, 8'h10);
      add_row(16'd6480, 8'h10);
      add_row(16'd6784, 8'h00);
      add_row(16'd6800, 8'h00);
      add_row(16'd7104, 8'h10);
      add_row(16'd7120, 8'h10);
      add_row(16'd7424, 8'hEF);
      add_row(16'd7440, 8'hFF);
      add_row(16'd7584, 8'h10);
      add_row(16'd9, 8'h00);
      add_row(16'd10, 8'h00);
      add_row(16'd19968, 8'h00);
      add_row(16'd19970, 8'h00);

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         offer_reading(directed_rows[i].raw, directed_rows[i].status,
                       directed_rows[i].typed, directed_rows[i].want);

      // Random phases: no idling (with one long receiver hold-off at the
      // start), sender idling, receiver stalling, then both at once.
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  hold_request = 1'b1; end
            1: begin tx_idle_pct = 63; rx_stall_pct = 0;  end
            2: begin tx_idle_pct = 0;  rx_stall_pct = 63; end
            default: begin tx_idle_pct = 25; rx_stall_pct = 25; end
         endcase
         for (int n = 0; n < RandomPerPhase; n++)
            offer_reading(random_reading(), StatusWidth'($urandom), 1'b0, none);
      end
      req_tvalid <= 1'b0;

      // Drain, then give stray results a chance to show up.
      while (pending_readouts.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);

      if (mismatch_count == 0 && stray_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
